// ===== design/dvrt_pkg.sv =====
`default_nettype none
package dvrt_pkg;

  localparam int ADDR_BITS_DEF     = 8;
  localparam int NEIGHBOR_BITS_DEF = 4;
  localparam int COST_BITS_DEF     = 8;

  // configuration port
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [CFG_IDX_BITS-1:0]  REG_LOCAL_COST  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0]  REG_HOP_COST    = 1'd1;
  localparam logic [CFG_DATA_BITS-1:0] LOCAL_COST_RST  = 8'd0;
  localparam logic [CFG_DATA_BITS-1:0] HOP_COST_RST    = 8'd1;

  typedef enum logic [1:0] {
    OP_LOOKUP    = 2'd0,
    OP_RELAX     = 2'd1,
    OP_ADD_LOCAL = 2'd2,
    OP_DROP      = 2'd3
  } op_t;

  // update command from the decision logic to the entry flops
  typedef struct packed {
    logic wr_en;
    logic wr_local;
    logic drop;
  } entry_cmd_t;

endpackage
`default_nettype wire

// ===== design/dvrt_ram.sv =====
`default_nettype none
module dvrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/dvrt_entry_array.sv =====
`default_nettype none
module dvrt_entry_array
  import dvrt_pkg::*;
#(
  parameter int ADDR_BITS     = ADDR_BITS_DEF,
  parameter int NEIGHBOR_BITS = NEIGHBOR_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire entry_cmd_t               cmd,
  input  wire logic [ADDR_BITS-1:0]     addr,
  input  wire logic [NEIGHBOR_BITS-1:0] wr_via,
  input  wire logic [NEIGHBOR_BITS-1:0] drop_nb,
  output logic                          rd_valid,
  output logic                          rd_local,
  output logic      [NEIGHBOR_BITS-1:0] rd_via,
  output logic                          drop_hit
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DEPTH-1:0]         valid_r;
  logic [DEPTH-1:0]         local_r;
  logic [NEIGHBOR_BITS-1:0] via_r [DEPTH];
  logic [DEPTH-1:0]         match;

  // every non-local route through the lost neighbour, all entries at once
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = valid_r[i] && !local_r[i] && (via_r[i] == drop_nb);
    end
  end

  assign drop_hit = |match;
  assign rd_valid = valid_r[addr];
  assign rd_local = local_r[addr];
  assign rd_via   = via_r[addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (cmd.drop && match[i]) begin
          valid_r[i] <= 1'b0;
        end else if (cmd.wr_en && (addr == ADDR_BITS'(i))) begin
          valid_r[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      local_r[addr] <= cmd.wr_local;
      via_r[addr]   <= wr_via;
    end
  end

`ifndef SYNTH
  a_wr_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.drop))
    else $error("entry write and drop in the same cycle");

  a_wr_takes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |=> (valid_r[$past(addr)] && (local_r[$past(addr)] == $past(cmd.wr_local))))
    else $error("written entry not valid with its local mark");
`endif

endmodule
`default_nettype wire

// ===== design/distance_vector_route_table_core.sv =====
`default_nettype none
// Directly indexed distance-vector route table. Each request (lookup, relax,
// add local, drop neighbour) is taken into an input register, decided against
// the entry flops and the cost RAM, and leaves through a result register: one
// request per cycle sustained while out_ready does not stall the output. Valid,
// local mark and next hop live in flops so drop-neighbour checks every entry at
// once; the cost sits in a RAM read at acceptance, with a bypass for a request
// that hits the address being written just ahead of it. Valid marks are cleared
// by reset, no clearing pass is needed. Configuration is to be written only
// while idle, which the block does not enforce; local_cost resets to 0, hop_cost to 1.
module distance_vector_route_table_core
  import dvrt_pkg::*;
#(
  parameter int ADDR_BITS     = ADDR_BITS_DEF,
  parameter int NEIGHBOR_BITS = NEIGHBOR_BITS_DEF,
  parameter int COST_BITS     = COST_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,

  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,

  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               in_operation,
  input  wire logic [ADDR_BITS-1:0]     in_address,
  input  wire logic [COST_BITS-1:0]     in_advertised_cost,
  input  wire logic [NEIGHBOR_BITS-1:0] in_neighbour,

  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_changed,
  output logic                          out_found,
  output logic                          out_is_local,
  output logic      [NEIGHBOR_BITS-1:0] out_next_hop,
  output logic      [COST_BITS-1:0]     out_route_cost
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [CFG_DATA_BITS-1:0] local_cost_r, hop_cost_r;

  logic                     s1_valid_r, s1_valid_nxt;
  op_t                      s1_op_r;
  logic [ADDR_BITS-1:0]     s1_addr_r;
  logic [COST_BITS-1:0]     s1_adv_r;
  logic [NEIGHBOR_BITS-1:0] s1_nb_r;

  logic                     fwd_valid_r, fwd_valid_nxt;
  logic [COST_BITS-1:0]     fwd_cost_r;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_changed_r, out_found_r, out_is_local_r;
  logic [NEIGHBOR_BITS-1:0] out_next_hop_r;
  logic [COST_BITS-1:0]     out_route_cost_r;

  logic                     in_fire, commit;
  logic [COST_BITS-1:0]     cost_rd, cur_cost, new_cost, actual;
  logic [COST_BITS:0]       sum;
  logic                     cost_we;
  entry_cmd_t               cmd;
  logic [NEIGHBOR_BITS-1:0] wr_via;
  logic                     rd_valid, rd_local, drop_hit;
  logic [NEIGHBOR_BITS-1:0] rd_via;
  logic                     changed, found, is_local;
  logic [NEIGHBOR_BITS-1:0] next_hop;
  logic [COST_BITS-1:0]     route_cost;

  assign commit   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || commit;
  assign in_fire  = in_valid && in_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_cost_r <= LOCAL_COST_RST;
      hop_cost_r   <= HOP_COST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_COST: local_cost_r <= cfg_wdata;
        REG_HOP_COST:   hop_cost_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  assign s1_valid_nxt = in_fire || (s1_valid_r && !commit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= op_t'(in_operation);
      s1_addr_r <= in_address;
      s1_adv_r  <= in_advertised_cost;
      s1_nb_r   <= in_neighbour;
    end
  end

  // the ram read at acceptance misses a write to the same address in that cycle
  always_comb begin
    if (in_fire) begin
      fwd_valid_nxt = cost_we && (in_address == s1_addr_r);
    end else if (commit) begin
      fwd_valid_nxt = 1'b0;
    end else begin
      fwd_valid_nxt = fwd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= fwd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_cost_r <= new_cost;
    end
  end

  dvrt_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (DEPTH)
  ) u_cost_ram (
    .clk     (clk),
    .wr_en   (cost_we),
    .wr_addr (s1_addr_r),
    .wr_data (new_cost),
    .rd_en   (in_fire),
    .rd_addr (in_address),
    .rd_data (cost_rd)
  );

  dvrt_entry_array #(
    .ADDR_BITS     (ADDR_BITS),
    .NEIGHBOR_BITS (NEIGHBOR_BITS)
  ) u_entries (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .addr     (s1_addr_r),
    .wr_via   (wr_via),
    .drop_nb  (s1_nb_r),
    .rd_valid (rd_valid),
    .rd_local (rd_local),
    .rd_via   (rd_via),
    .drop_hit (drop_hit)
  );

  assign cur_cost = fwd_valid_r ? fwd_cost_r : cost_rd;

  // saturating advertised cost plus hop cost
  assign sum    = {1'b0, s1_adv_r} + {1'b0, COST_BITS'(hop_cost_r)};
  assign actual = sum[COST_BITS] ? '1 : sum[COST_BITS-1:0];

  always_comb begin
    cmd        = '0;
    cost_we    = 1'b0;
    new_cost   = actual;
    wr_via     = s1_nb_r;
    changed    = 1'b0;
    found      = 1'b0;
    is_local   = 1'b0;
    next_hop   = '0;
    route_cost = '0;
    case (s1_op_r)
      OP_LOOKUP: begin
        if (rd_valid) begin
          found      = 1'b1;
          is_local   = rd_local;
          next_hop   = rd_local ? '0 : rd_via;
          route_cost = cur_cost;
        end
      end
      OP_RELAX: begin
        if (!rd_valid) begin
          cmd.wr_en = 1'b1;
          cost_we   = 1'b1;
          changed   = 1'b1;
        end else if (!rd_local && (rd_via == s1_nb_r)) begin
          // same neighbour: take its new cost whatever it is
          if (cur_cost != actual) begin
            cost_we = 1'b1;
            changed = 1'b1;
          end
        end else if (cur_cost > actual) begin
          cmd.wr_en = 1'b1;
          cost_we   = 1'b1;
          changed   = 1'b1;
        end
      end
      OP_ADD_LOCAL: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_local = 1'b1;
        cost_we      = 1'b1;
        new_cost     = COST_BITS'(local_cost_r);
        wr_via       = '0;
        changed      = 1'b1;
      end
      OP_DROP: begin
        cmd.drop = 1'b1;
        changed  = drop_hit;
      end
      default: ;
    endcase
    if (!commit) begin
      cmd     = '0;
      cost_we = 1'b0;
    end
  end

  // result register
  assign out_valid_nxt = commit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_changed_r    <= changed;
      out_found_r      <= found;
      out_is_local_r   <= is_local;
      out_next_hop_r   <= next_hop;
      out_route_cost_r <= route_cost;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_changed    = out_changed_r;
  assign out_found      = out_found_r;
  assign out_is_local   = out_is_local_r;
  assign out_next_hop   = out_next_hop_r;
  assign out_route_cost = out_route_cost_r;

`ifndef SYNTH
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("decided request did not reach the result register");

  a_fwd_held: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_valid_r |-> s1_valid_r)
    else $error("cost bypass set with no request in the input register");

  a_lookup_nochange: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> !out_changed_r)
    else $error("lookup result reports a table change");
`endif

endmodule
`default_nettype wire
